// ===== design/otbf_pkg.sv =====
// Shared constants and opcodes for the overwriting text byte FIFO.
package otbf_pkg;

    // Storage depth in bytes and the widths that follow from it.
    localparam int FIFO_DEPTH = 32;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // Fixed field widths of the word interface.
    localparam int OPCODE_W = 2;
    localparam int BYTE_W   = 8;
    localparam int COUNT_W  = 6;

    // Operation codes.
    localparam logic [OPCODE_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_POP   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_NONE  = 2'd3;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Ring increment of a storage pointer.
    function automatic ptr_t next_slot(input ptr_t p);
        ptr_t last;
        last = ptr_t'(FIFO_DEPTH - 1);
        return (p == last) ? '0 : ptr_t'(p + ptr_t'(1));
    endfunction

endpackage

// ===== design/otbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module otbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; a read of the address being
    // written returns the old contents.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== design/overwriting_text_byte_fifo_core.sv =====
// Overwriting text byte FIFO: a ring of text bytes with push, pop and clear,
// and one status word returned for every operation word. A push into a full
// FIFO overwrites the oldest byte. An accepted word is held as a pending
// status and then loaded into the output register, so with the result side
// free the block takes one word per cycle; the byte RAM has a registered read
// port and is read at the new oldest position while the pointers are updated.
// A stall on the result side holds the pending status and the block then
// stalls its input.
module overwriting_text_byte_fifo_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  logic [otbf_pkg::OPCODE_W-1:0]  opcode,
    input  logic [otbf_pkg::BYTE_W-1:0]    data_byte,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [otbf_pkg::COUNT_W-1:0]   byte_count,
    output logic [otbf_pkg::BYTE_W-1:0]    front_byte,
    output logic                           text_ready,
    output logic                           text_event
);
    import otbf_pkg::*;

    ptr_t wr_ptr_reg, wr_ptr_next;
    ptr_t rd_ptr_reg, rd_ptr_next;
    cnt_t cnt_reg, cnt_next;
    logic push_next;

    logic pend_reg, pend_next;
    logic pend_event_reg;
    logic fwd_hit_reg;
    logic [BYTE_W-1:0] fwd_data_reg;

    logic result_valid_reg, result_valid_next;
    logic [COUNT_W-1:0] count_out_reg;
    logic [BYTE_W-1:0] front_out_reg;
    logic ready_out_reg;
    logic event_out_reg;

    logic accept;
    logic load_out;
    ptr_t ram_rd_addr;
    logic [BYTE_W-1:0] ram_rd_data;
    logic [BYTE_W-1:0] front_sel;
    logic [CNT_W+COUNT_W-1:0] count_wide;

    // Handshake: a pending status moves to the output register when it is free.
    assign accept     = item_valid && !item_stall;
    assign load_out   = pend_reg && (!result_valid_reg || !result_stall);
    assign item_stall = pend_reg && !load_out;

    // Pointer and count update for the incoming operation.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        push_next   = 1'b0;
        unique case (opcode)
            OP_PUSH:
            begin
                push_next   = 1'b1;
                wr_ptr_next = next_slot(wr_ptr_reg);
                if (cnt_reg == cnt_t'(FIFO_DEPTH))
                begin
                    rd_ptr_next = next_slot(rd_ptr_reg);
                end
                else
                begin
                    cnt_next = cnt_t'(cnt_reg + cnt_t'(1));
                end
            end
            OP_POP:
            begin
                if (cnt_reg != '0)
                begin
                    rd_ptr_next = next_slot(rd_ptr_reg);
                    cnt_next    = cnt_t'(cnt_reg - cnt_t'(1));
                end
            end
            OP_CLEAR:
            begin
                rd_ptr_next = wr_ptr_reg;
                cnt_next    = '0;
            end
            OP_NONE:
            begin
                cnt_next = cnt_reg;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Byte store; read at the new oldest position on accept, else hold it.
    assign ram_rd_addr = accept ? rd_ptr_next : rd_ptr_reg;

    otbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && push_next),
        .wr_addr (wr_ptr_reg),
        .wr_data (data_byte),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Control state.
    assign pend_next = accept ? 1'b1 : (load_out ? 1'b0 : pend_reg);
    assign result_valid_next = load_out ? 1'b1
                             : (result_stall ? result_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            cnt_reg          <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                wr_ptr_reg <= wr_ptr_next;
                rd_ptr_reg <= rd_ptr_next;
                cnt_reg    <= cnt_next;
            end
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Forwarding of a byte written to the slot that is read in the same cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_event_reg <= push_next;
            fwd_hit_reg    <= push_next && (wr_ptr_reg == rd_ptr_next);
            fwd_data_reg   <= data_byte;
        end
    end

    // Status word assembly.
    assign front_sel  = (cnt_reg == '0) ? '0
                      : (fwd_hit_reg ? fwd_data_reg : ram_rd_data);
    assign count_wide = {{COUNT_W{1'b0}}, cnt_reg};

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            count_out_reg <= count_wide[COUNT_W-1:0];
            front_out_reg <= front_sel;
            ready_out_reg <= (cnt_reg != '0);
            event_out_reg <= pend_event_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign byte_count   = count_out_reg;
    assign front_byte   = front_out_reg;
    assign text_ready   = ready_out_reg;
    assign text_event   = event_out_reg;

endmodule

// ===== design/otbf_checker.sv =====
// Port-level checker for the overwriting text byte FIFO, bound to the core.
module otbf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          result_valid,
    input logic                          result_stall,
    input logic [otbf_pkg::COUNT_W-1:0]  byte_count,
    input logic [otbf_pkg::BYTE_W-1:0]   front_byte,
    input logic                          text_ready,
    input logic                          text_event
);
    import otbf_pkg::*;

    // A stalled status word stays valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("status word dropped while stalled");

    // A stalled status word holds its fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(byte_count) && $stable(front_byte))
        else $error("status word changed while stalled");

    // The ready flag agrees with the count.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (text_ready == (byte_count != '0)))
        else $error("ready flag disagrees with byte count");

    // An empty FIFO reports a zero front byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !text_ready |-> (front_byte == '0))
        else $error("front byte nonzero while empty");

    // A push always leaves at least one byte held.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && text_event |-> text_ready)
        else $error("push reported an empty FIFO");

endmodule

bind overwriting_text_byte_fifo_core otbf_checker u_otbf_checker (.*);
